>>> rtl/rvbc_pkg.sv
`default_nettype none

package rvbc_pkg;

  // Field widths of the pose and corner items.
  localparam int SCALE_W = 24;
  localparam int COORD_W = 13;
  localparam int ALT_W   = 10;
  localparam int HEAD_W  = 9;
  localparam int PIX_W   = 16;

  // Altitude times scale, then the half size after dropping 16 fraction bits and halving.
  localparam int PROD_W     = ALT_W + SCALE_W;
  localparam int HALF_SHIFT = 17;
  localparam int HALF_W     = PROD_W - HALF_SHIFT;

  // Quarter-wave sine table covers 0 to 90 degrees.
  localparam int TAB_DEPTH = 91;
  localparam int IDX_W     = 7;

  localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
  localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
  localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
  localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

  localparam logic [SCALE_W-1:0] WIDTH_SCALE_RESET  = 24'd504336;
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RESET = 24'd283178;

  localparam logic [1:0] LAST_CORNER_INDEX = 2'd3;

  typedef enum logic {
    CFG_WIDTH_SCALE  = 1'b0,
    CFG_HEIGHT_SCALE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [ALT_W-1:0]   altitude;
    logic [HEAD_W-1:0]  heading_deg;
  } pose_t;

  typedef struct packed {
    logic [1:0]              corner_index;
    logic signed [PIX_W-1:0] corner_x;
    logic signed [PIX_W-1:0] corner_y;
    logic                    last_corner;
  } corner_t;

  // Pi with 60 fraction bits and its split by 180 for degree to radian conversion.
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_DIV     = 64'd180;
  localparam logic [63:0] PI_DEG_Q60  = PI_Q60 / DEG_DIV;
  localparam logic [63:0] PI_DEG_REM  = PI_Q60 % DEG_DIV;
  localparam int unsigned SERIES_TERMS = 40;

  // Unsigned quotient by restoring long division, truncated like integer division.
  // Only used to build constant tables during elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sine of a whole degree from 0 to 90 with 60 fraction bits, by the Taylor series.
  // Only used to build constant tables during elaboration.
  function automatic logic [63:0] sin_q60(input int unsigned deg);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] prod;
    logic [63:0]  divisor;
    x    = PI_DEG_Q60 * 64'(deg) + div_u64(PI_DEG_REM * 64'(deg), DEG_DIV);
    prod = 128'(x) * 128'(x);
    x2   = prod[123:60];
    term = x;
    sum  = x;
    for (int unsigned n = 1; n < SERIES_TERMS; n++) begin
      if (term != 64'd0) begin
        prod    = 128'(term) * 128'(x2);
        divisor = 64'(2 * n) * 64'(2 * n + 1);
        term    = div_u64(prod[123:60], divisor);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rvbc_front.sv
`default_nettype none

module rvbc_front import rvbc_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               up_valid,
  output logic                                    up_ready,
  input  wire pose_t                              pose,
  input  wire logic [SCALE_W-1:0]                 width_scale,
  input  wire logic [SCALE_W-1:0]                 height_scale,
  output logic                                    down_valid,
  input  wire logic                               down_ready,
  output logic [HALF_W-1:0]                       half_w,
  output logic [HALF_W-1:0]                       half_h,
  output logic signed [TRIG_FRAC_BITS+1:0]        sin_v,
  output logic signed [TRIG_FRAC_BITS+1:0]        cos_v,
  output logic [COORD_W-1:0]                      cx,
  output logic [COORD_W-1:0]                      cy
);

  // Quarter-wave sine magnitudes, rounded to nearest at TRIG_FRAC_BITS.
  logic [TRIG_FRAC_BITS:0] sin_tab [TAB_DEPTH];

  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    localparam logic [63:0] RAW = sin_q60(g);
    localparam logic [63:0] RND = (RAW + (64'd1 << (59 - TRIG_FRAC_BITS)))
                                  >> (60 - TRIG_FRAC_BITS);
    assign sin_tab[g] = RND[TRIG_FRAC_BITS:0];
  end

  // Stage one: scale products and heading folding into one quadrant.
  logic                s1_valid;
  logic [PROD_W-1:0]   s1_wprod;
  logic [PROD_W-1:0]   s1_hprod;
  logic [IDX_W-1:0]    s1_sin_idx;
  logic [IDX_W-1:0]    s1_cos_idx;
  logic                s1_sin_neg;
  logic                s1_cos_neg;
  logic [COORD_W-1:0]  s1_cx;
  logic [COORD_W-1:0]  s1_cy;
  logic                s1_ready;
  logic                s2_ready;

  logic [HEAD_W-1:0]   head_mod;
  logic [IDX_W-1:0]    sin_idx_next;
  logic [IDX_W-1:0]    cos_idx_next;
  logic                sin_neg_next;
  logic                cos_neg_next;

  assign head_mod = (pose.heading_deg >= DEG_360) ? pose.heading_deg - DEG_360
                                                  : pose.heading_deg;

  always_comb begin
    priority if (head_mod <= DEG_90) begin
      sin_idx_next = IDX_W'(head_mod);
      cos_idx_next = IDX_W'(DEG_90 - head_mod);
      sin_neg_next = 1'b0;
      cos_neg_next = 1'b0;
    end else if (head_mod <= DEG_180) begin
      sin_idx_next = IDX_W'(DEG_180 - head_mod);
      cos_idx_next = IDX_W'(head_mod - DEG_90);
      sin_neg_next = 1'b0;
      cos_neg_next = 1'b1;
    end else if (head_mod <= DEG_270) begin
      sin_idx_next = IDX_W'(head_mod - DEG_180);
      cos_idx_next = IDX_W'(DEG_270 - head_mod);
      sin_neg_next = 1'b1;
      cos_neg_next = 1'b1;
    end else begin
      sin_idx_next = IDX_W'(DEG_360 - head_mod);
      cos_idx_next = IDX_W'(head_mod - DEG_270);
      sin_neg_next = 1'b1;
      cos_neg_next = 1'b0;
    end
  end

  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_wprod   <= PROD_W'(pose.altitude) * PROD_W'(width_scale);
      s1_hprod   <= PROD_W'(pose.altitude) * PROD_W'(height_scale);
      s1_sin_idx <= sin_idx_next;
      s1_cos_idx <= cos_idx_next;
      s1_sin_neg <= sin_neg_next;
      s1_cos_neg <= cos_neg_next;
      s1_cx      <= pose.center_x;
      s1_cy      <= pose.center_y;
    end
  end

  // Stage two: table lookup with sign, and the half sizes.
  logic signed [TRIG_FRAC_BITS+1:0] sin_mag;
  logic signed [TRIG_FRAC_BITS+1:0] cos_mag;

  assign sin_mag  = $signed({1'b0, sin_tab[s1_sin_idx]});
  assign cos_mag  = $signed({1'b0, sin_tab[s1_cos_idx]});
  assign s2_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (s2_ready) begin
      down_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      half_w <= s1_wprod[PROD_W-1:HALF_SHIFT];
      half_h <= s1_hprod[PROD_W-1:HALF_SHIFT];
      sin_v  <= s1_sin_neg ? -sin_mag : sin_mag;
      cos_v  <= s1_cos_neg ? -cos_mag : cos_mag;
      cx     <= s1_cx;
      cy     <= s1_cy;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rvbc_rotate.sv
`default_nettype none

module rvbc_rotate import rvbc_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 16,
  parameter int PW = HALF_W + TRIG_FRAC_BITS + 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               up_valid,
  output logic                                    up_ready,
  input  wire logic [HALF_W-1:0]                  half_w,
  input  wire logic [HALF_W-1:0]                  half_h,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]   sin_v,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]   cos_v,
  input  wire logic [COORD_W-1:0]                 cx_in,
  input  wire logic [COORD_W-1:0]                 cy_in,
  output logic                                    down_valid,
  input  wire logic                               down_ready,
  output logic signed [PW-1:0]                    p_wc,
  output logic signed [PW-1:0]                    p_hs,
  output logic signed [PW-1:0]                    p_hc,
  output logic signed [PW-1:0]                    p_ws,
  output logic [COORD_W-1:0]                      cx,
  output logic [COORD_W-1:0]                      cy
);

  // Four products of the half sizes with sine and cosine; corner signs come later.
  logic signed [HALF_W:0] hw_s;
  logic signed [HALF_W:0] hh_s;

  assign hw_s     = $signed({1'b0, half_w});
  assign hh_s     = $signed({1'b0, half_h});
  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p_wc <= hw_s * cos_v;
      p_hs <= hh_s * sin_v;
      p_hc <= hh_s * cos_v;
      p_ws <= hw_s * sin_v;
      cx   <= cx_in;
      cy   <= cy_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rvbc_corner.sv
`default_nettype none

module rvbc_corner import rvbc_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 16,
  parameter int PW = HALF_W + TRIG_FRAC_BITS + 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire logic signed [PW-1:0]  p_wc,
  input  wire logic signed [PW-1:0]  p_hs,
  input  wire logic signed [PW-1:0]  p_hc,
  input  wire logic signed [PW-1:0]  p_ws,
  input  wire logic [COORD_W-1:0]    cx,
  input  wire logic [COORD_W-1:0]    cy,
  output logic                       corner_valid,
  input  wire logic                  corner_stall,
  output corner_t                    corner
);

  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] PIX_MAX = SW'(32767);
  localparam logic signed [SW-1:0] PIX_MIN = SW'(-32768);

  // Holder: keeps one box and hands out its corners one at a time.
  logic                h_valid;
  logic [1:0]          h_cnt;
  logic signed [PW-1:0] h_wc;
  logic signed [PW-1:0] h_hs;
  logic signed [PW-1:0] h_hc;
  logic signed [PW-1:0] h_ws;
  logic [COORD_W-1:0]  h_cx;
  logic [COORD_W-1:0]  h_cy;

  logic sum_valid;
  logic sum_ready;
  logic out_ready;
  logic fire;
  logic take;

  assign fire     = h_valid && sum_ready;
  assign up_ready = !h_valid || (fire && h_cnt == LAST_CORNER_INDEX);
  assign take     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      h_cnt   <= 2'd0;
    end else if (take) begin
      h_valid <= 1'b1;
      h_cnt   <= 2'd0;
    end else if (fire) begin
      h_valid <= (h_cnt != LAST_CORNER_INDEX);
      h_cnt   <= h_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_wc <= p_wc;
      h_hs <= p_hs;
      h_hc <= p_hc;
      h_ws <= p_ws;
      h_cx <= cx;
      h_cy <= cy;
    end
  end

  // Corner signs: x offset is negative on corners 0 and 3, y offset on corners 2 and 3.
  logic                 neg_dx;
  logic                 neg_dy;
  logic signed [SW-1:0] e_wc;
  logic signed [SW-1:0] e_hs;
  logic signed [SW-1:0] e_hc;
  logic signed [SW-1:0] e_ws;
  logic signed [SW-1:0] ctr_x;
  logic signed [SW-1:0] ctr_y;
  logic signed [SW-1:0] sum_x_next;
  logic signed [SW-1:0] sum_y_next;

  assign neg_dx = (h_cnt == 2'd0) || (h_cnt == LAST_CORNER_INDEX);
  assign neg_dy = h_cnt[1];
  assign e_wc   = SW'(h_wc);
  assign e_hs   = SW'(h_hs);
  assign e_hc   = SW'(h_hc);
  assign e_ws   = SW'(h_ws);
  assign ctr_x  = SW'(h_cx) << TRIG_FRAC_BITS;
  assign ctr_y  = SW'(h_cy) << TRIG_FRAC_BITS;

  // x = dx*cos - dy*sin + cx, y = dy*cos + dx*sin + cy
  assign sum_x_next = (neg_dx ? -e_wc : e_wc) + (neg_dy ? e_hs : -e_hs) + ctr_x;
  assign sum_y_next = (neg_dy ? -e_hc : e_hc) + (neg_dx ? -e_ws : e_ws) + ctr_y;

  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic [1:0]           sum_idx;

  assign sum_ready = !sum_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_x   <= sum_x_next;
      sum_y   <= sum_y_next;
      sum_idx <= h_cnt;
    end
  end

  // Output stage: truncate toward zero to whole pixels, then clamp to 16 bits.
  logic signed [SW-1:0] shx;
  logic signed [SW-1:0] shy;
  logic signed [SW-1:0] qx;
  logic signed [SW-1:0] qy;
  logic signed [PIX_W-1:0] pix_x;
  logic signed [PIX_W-1:0] pix_y;

  assign shx = sum_x >>> TRIG_FRAC_BITS;
  assign shy = sum_y >>> TRIG_FRAC_BITS;
  assign qx  = shx + $signed(SW'(sum_x[SW-1] && (|sum_x[TRIG_FRAC_BITS-1:0])));
  assign qy  = shy + $signed(SW'(sum_y[SW-1] && (|sum_y[TRIG_FRAC_BITS-1:0])));

  always_comb begin
    priority if (qx > PIX_MAX) begin
      pix_x = PIX_MAX[PIX_W-1:0];
    end else if (qx < PIX_MIN) begin
      pix_x = PIX_MIN[PIX_W-1:0];
    end else begin
      pix_x = qx[PIX_W-1:0];
    end
    priority if (qy > PIX_MAX) begin
      pix_y = PIX_MAX[PIX_W-1:0];
    end else if (qy < PIX_MIN) begin
      pix_y = PIX_MIN[PIX_W-1:0];
    end else begin
      pix_y = qy[PIX_W-1:0];
    end
  end

  assign out_ready = !corner_valid || !corner_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
    end else if (out_ready) begin
      corner_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && sum_valid) begin
      corner.corner_index <= sum_idx;
      corner.corner_x     <= pix_x;
      corner.corner_y     <= pix_y;
      corner.last_corner  <= (sum_idx == LAST_CORNER_INDEX);
    end
  end

  // The holder never sits mid-box without an item.
  a_cnt_needs_item: assert property (@(posedge clk) disable iff (rst)
    h_cnt != 2'd0 |-> h_valid)
    else $error("corner counter running with an empty holder");

  // Once a non-final corner is taken, the next corner of the same box is ready at once.
  a_corner_follows: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_stall && !corner.last_corner |=>
      corner_valid && corner.corner_index == $past(corner.corner_index) + 2'd1)
    else $error("corner sequence broke inside a box");

  // The final flag and the fourth index always agree.
  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> (corner.last_corner == (corner.corner_index == LAST_CORNER_INDEX)))
    else $error("last corner flag disagrees with corner index");

endmodule

`default_nettype wire

>>> rtl/rotated_view_box_corners.sv
// Channel   | Direction | Handshake                  | Payload
// pose      | in        | pose_valid / pose_stall    | pose_t: center, altitude, heading
// corner    | out       | corner_valid / corner_stall| corner_t: index, x, y, last flag
// cfg       | in        | cfg_write                  | cfg_index, cfg_data (24 bit scale)
//
// Each pose item yields four corner items, one per cycle unless the corner side
// stalls; the corner holder frees up only as its fourth corner moves on. The first
// corner passes the two front stages, the rotation stage, the holder, the sum register
// and the output register. From empty, four poses are taken back to back (two front
// stages, the rotation stage and the holder), after that only as the holder frees up.
// Reset is synchronous and clears all valid bits; the scales return to their defaults.
// A stall on the corner side holds the corner and backs up the pipeline without loss.

`default_nettype none

module rotated_view_box_corners import rvbc_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pose_valid,
  output logic                      pose_stall,
  input  wire pose_t                pose,
  output logic                      corner_valid,
  input  wire logic                 corner_stall,
  output corner_t                   corner,
  input  wire logic                 cfg_write,
  input  wire cfg_reg_t             cfg_index,
  input  wire logic [SCALE_W-1:0]   cfg_data
);

  // Width of the rotated products: half size (with sign bit) times signed trig value.
  localparam int PW = HALF_W + TRIG_FRAC_BITS + 3;

  // Box scale registers. Users must write only while the block is idle; not enforced.
  logic [SCALE_W-1:0] width_scale;
  logic [SCALE_W-1:0] height_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_scale  <= WIDTH_SCALE_RESET;
      height_scale <= HEIGHT_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH_SCALE:  width_scale  <= cfg_data;
        CFG_HEIGHT_SCALE: height_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: two stages. The first forms altitude times scale and folds the heading
  // into a quadrant; the second reads the quarter-wave sine table and halves the box.
  logic                             f_valid;
  logic                             f_ready;
  logic                             front_ready;
  logic [HALF_W-1:0]                f_half_w;
  logic [HALF_W-1:0]                f_half_h;
  logic signed [TRIG_FRAC_BITS+1:0] f_sin;
  logic signed [TRIG_FRAC_BITS+1:0] f_cos;
  logic [COORD_W-1:0]               f_cx;
  logic [COORD_W-1:0]               f_cy;

  rvbc_front #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (pose_valid),
    .up_ready    (front_ready),
    .pose        (pose),
    .width_scale (width_scale),
    .height_scale(height_scale),
    .down_valid  (f_valid),
    .down_ready  (f_ready),
    .half_w      (f_half_w),
    .half_h      (f_half_h),
    .sin_v       (f_sin),
    .cos_v       (f_cos),
    .cx          (f_cx),
    .cy          (f_cy)
  );

  assign pose_stall = !front_ready;

  // Rotation: one stage of four multipliers shared by all four corners of a box.
  logic                 r_valid;
  logic                 r_ready;
  logic signed [PW-1:0] r_wc;
  logic signed [PW-1:0] r_hs;
  logic signed [PW-1:0] r_hc;
  logic signed [PW-1:0] r_ws;
  logic [COORD_W-1:0]   r_cx;
  logic [COORD_W-1:0]   r_cy;

  rvbc_rotate #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .PW            (PW)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (f_valid),
    .up_ready  (f_ready),
    .half_w    (f_half_w),
    .half_h    (f_half_h),
    .sin_v     (f_sin),
    .cos_v     (f_cos),
    .cx_in     (f_cx),
    .cy_in     (f_cy),
    .down_valid(r_valid),
    .down_ready(r_ready),
    .p_wc      (r_wc),
    .p_hs      (r_hs),
    .p_hc      (r_hc),
    .p_ws      (r_ws),
    .cx        (r_cx),
    .cy        (r_cy)
  );

  // Corner sequencer: holds a box, forms one corner sum per cycle unless the output
  // stalls, then truncates, clamps and registers it on the corner channel.
  rvbc_corner #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .PW            (PW)
  ) u_corner (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (r_valid),
    .up_ready    (r_ready),
    .p_wc        (r_wc),
    .p_hs        (r_hs),
    .p_hc        (r_hc),
    .p_ws        (r_ws),
    .cx          (r_cx),
    .cy          (r_cy),
    .corner_valid(corner_valid),
    .corner_stall(corner_stall),
    .corner      (corner)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvbc_pkg::*;

  // Fixed-point trig uses 16 fraction bits, same as the block's default parameter.
  localparam int          FRAC_BITS = 16;
  localparam longint      ONE_Q     = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0] PI_FIX60  = 64'h3243F6A8885A308D;

  localparam logic [SCALE_W-1:0] DEFAULT_WIDTH_SCALE  = 24'd504336;
  localparam logic [SCALE_W-1:0] DEFAULT_HEIGHT_SCALE = 24'd283178;
  localparam logic [SCALE_W-1:0] FULL_SCALE           = 24'hFFFFFF;

  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT     = 2000;
  // Quiet cycles after the last corner, to catch anything extra coming out.
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASES         = 6;
  localparam int POSES_PER_PHASE = 25;

  // Order in which the block emits the box corners.
  typedef enum int {
    BOTTOM_LEFT  = 0,
    BOTTOM_RIGHT = 1,
    TOP_RIGHT    = 2,
    TOP_LEFT     = 3
  } corner_pos_e;

  // One row of the directed stimulus. When pinned is set, all four corners are
  // known by inspection to sit at (px, py); otherwise the predictor decides.
  typedef struct {
    int cx;
    int cy;
    int alt;
    int hdg;
    bit pinned;
    int px;
    int py;
  } pose_row_t;

  localparam int DIR_ROWS = 22;

  // Zero-altitude rows collapse the box onto its center, at two map corners and
  // mid-map, with headings inside and beyond one turn. Others sweep the quadrant
  // boundaries, full altitude, headings past 359 and alternating bit patterns.
  pose_row_t dir_rows [DIR_ROWS] = '{
    '{0,    0,    0,    0,   1'b1, 0,    0   },
    '{8191, 8191, 0,    359, 1'b1, 8191, 8191},
    '{4096, 4096, 0,    511, 1'b1, 4096, 4096},
    '{1000, 2000, 1,    0,   1'b0, 0,    0   },
    '{1000, 2000, 1023, 0,   1'b0, 0,    0   },
    '{4096, 4096, 1023, 90,  1'b0, 0,    0   },
    '{4096, 4096, 1023, 180, 1'b0, 0,    0   },
    '{4096, 4096, 1023, 270, 1'b0, 0,    0   },
    '{4096, 4096, 1023, 359, 1'b0, 0,    0   },
    '{4096, 4096, 1023, 360, 1'b0, 0,    0   },
    '{4096, 4096, 1023, 450, 1'b0, 0,    0   },
    '{4096, 4096, 1023, 511, 1'b0, 0,    0   },
    '{0,    0,    1023, 45,  1'b0, 0,    0   },
    '{8191, 8191, 1023, 225, 1'b0, 0,    0   },
    '{0,    8191, 512,  135, 1'b0, 0,    0   },
    '{8191, 0,    512,  315, 1'b0, 0,    0   },
    '{5461, 2730, 341,  170, 1'b0, 0,    0   },
    '{2730, 5461, 682,  341, 1'b0, 0,    0   },
    '{1,    1,    1,    1,   1'b0, 0,    0   },
    '{8190, 8190, 1022, 89,  1'b0, 0,    0   },
    '{123,  456,  300,  30,  1'b0, 0,    0   },
    '{7000, 300,  700,  60,  1'b0, 0,    0   }
  };

  logic clk = 1'b0;
  logic rst;

  logic             pose_valid;
  logic             pose_stall;
  pose_t            pose;
  logic             corner_valid;
  logic             corner_stall;
  corner_t          corner;
  logic             cfg_write;
  cfg_reg_t         cfg_index;
  logic [SCALE_W-1:0] cfg_data;

  rotated_view_box_corners dut (
    .clk          (clk),
    .rst          (rst),
    .pose_valid   (pose_valid),
    .pose_stall   (pose_stall),
    .pose         (pose),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner       (corner),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Testbench copy of the two scale registers.
  logic [SCALE_W-1:0] width_scale_q;
  logic [SCALE_W-1:0] height_scale_q;

  // Sine of 0 to 90 degrees, rounded to FRAC_BITS fraction bits.
  longint sine_q16 [0:90];

  corner_t pending_corners [$];
  int      errors;
  int      stall_left;
  int      idle_cycles;
  bit      idle_en;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Taylor series for sin at 60 fraction bits, then rounded to nearest at
  // FRAC_BITS. The degree-to-radian step splits pi/180 into quotient and
  // remainder so the conversion stays exact to the last bit.
  function automatic longint quarter_sine(input int unsigned deg);
    logic [63:0]  ang;
    logic [63:0]  sq;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [127:0] prod;
    ang  = (PI_FIX60 / 64'd180) * 64'(deg) + ((PI_FIX60 % 64'd180) * 64'(deg)) / 64'd180;
    prod = {64'd0, ang} * {64'd0, ang};
    sq   = prod[123:60];
    term = ang;
    acc  = ang;
    for (int unsigned n = 1; n < 40 && term != 64'd0; n++) begin
      prod = {64'd0, term} * {64'd0, sq};
      term = prod[123:60] / (64'(2 * n) * 64'(2 * n + 1));
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    return longint'(acc);
  endfunction

  // Truncate toward zero to whole pixels, then saturate to 16 bits signed.
  function automatic logic signed [PIX_W-1:0] clamp_pixel(input longint v);
    longint whole;
    whole = v / ONE_Q;
    if (whole > 32767) begin
      whole = 32767;
    end else if (whole < -32768) begin
      whole = -32768;
    end
    return PIX_W'(whole);
  endfunction

  // Works out the four rotated footprint corners of one pose and queues them.
  function automatic void predict_footprint(input pose_t p);
    longint      cx, cy, w, h, hw, hh, s, c, dx, dy, x, y;
    int unsigned hd;
    corner_t     e;
    cx = longint'(p.center_x);
    cy = longint'(p.center_y);
    w  = (longint'(p.altitude) * longint'(width_scale_q)) >>> 16;
    h  = (longint'(p.altitude) * longint'(height_scale_q)) >>> 16;
    hw = w / 2;
    hh = h / 2;
    hd = int'(p.heading_deg) % 360;
    // Fold the heading into the first quadrant and fix up the signs.
    if (hd <= 90) begin
      s = sine_q16[hd];
      c = sine_q16[90 - hd];
    end else if (hd <= 180) begin
      s = sine_q16[180 - hd];
      c = -sine_q16[hd - 90];
    end else if (hd <= 270) begin
      s = -sine_q16[hd - 180];
      c = -sine_q16[270 - hd];
    end else begin
      s = -sine_q16[360 - hd];
      c = sine_q16[hd - 270];
    end
    for (int k = BOTTOM_LEFT; k <= TOP_LEFT; k++) begin
      dx = (k == BOTTOM_LEFT || k == TOP_LEFT) ? -hw : hw;
      dy = (k == BOTTOM_LEFT || k == BOTTOM_RIGHT) ? hh : -hh;
      x  = dx * c - dy * s + cx * ONE_Q;
      y  = dy * c + dx * s + cy * ONE_Q;
      e.corner_index = 2'(k);
      e.corner_x     = clamp_pixel(x);
      e.corner_y     = clamp_pixel(y);
      e.last_corner  = (k == TOP_LEFT);
      pending_corners.push_back(e);
    end
  endfunction

  // Pose payloads for the random part. Altitude leans small now and then so
  // that boxes stay on the map under the large scales; headings cover the
  // quadrant boundaries and the values past one turn that the field allows.
  function automatic pose_t random_pose();
    pose_t p;
    p.center_x = COORD_W'($urandom_range(0, 8191));
    p.center_y = COORD_W'($urandom_range(0, 8191));
    if ($urandom_range(0, 3) == 0) begin
      p.altitude = ALT_W'($urandom_range(0, 15));
    end else begin
      p.altitude = ALT_W'($urandom_range(0, 1023));
    end
    case ($urandom_range(0, 7))
      0:       p.heading_deg = HEAD_W'($urandom_range(360, 511));
      1:       p.heading_deg = HEAD_W'($urandom_range(0, 5) * 90);
      default: p.heading_deg = HEAD_W'($urandom_range(0, 359));
    endcase
    return p;
  endfunction

  // Called at a falling edge. Presents one pose, holds it until taken, queues
  // its expected corners, and returns at a falling edge, now and then after an
  // idle gap. A pinned pose has its four corners typed in instead of predicted.
  task automatic send_pose(input pose_t p, input bit pinned,
                           input logic signed [PIX_W-1:0] px,
                           input logic signed [PIX_W-1:0] py);
    corner_t e;
    pose_valid <= 1'b1;
    pose       <= p;
    do begin
      @(posedge clk);
    end while (pose_stall);
    if (pinned) begin
      for (int k = BOTTOM_LEFT; k <= TOP_LEFT; k++) begin
        e.corner_index = 2'(k);
        e.corner_x     = px;
        e.corner_y     = py;
        e.last_corner  = (k == TOP_LEFT);
        pending_corners.push_back(e);
      end
    end else begin
      predict_footprint(p);
    end
    @(negedge clk);
    // Sender gaps come at random while idling is enabled.
    if (idle_en && $urandom_range(0, 4) == 0) begin
      pose_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // Stop sending and wait at falling edges until every queued corner is out.
  task automatic drain_corners();
    pose_valid <= 1'b0;
    while (pending_corners.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes both scales back to back while the block is idle.
  task automatic set_scales(input logic [SCALE_W-1:0] w, input logic [SCALE_W-1:0] h);
    cfg_write      <= 1'b1;
    cfg_index      <= CFG_WIDTH_SCALE;
    cfg_data       <= w;
    width_scale_q  = w;
    @(negedge clk);
    cfg_index      <= CFG_HEIGHT_SCALE;
    cfg_data       <= h;
    height_scale_q = h;
    @(negedge clk);
    cfg_write      <= 1'b0;
  endtask

  // The result side stalls in random bursts while idling is enabled, and is
  // always ready otherwise.
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      corner_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      corner_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      corner_stall <= 1'b1;
    end else begin
      corner_stall <= 1'b0;
    end
  end

  // Every accepted corner is compared with the oldest expectation.
  always @(posedge clk) begin
    corner_t want;
    if (!rst && corner_valid === 1'b1 && corner_stall == 1'b0) begin
      if (pending_corners.size() == 0) begin
        flag_error($sformatf("unexpected corner: idx %0d x %0d y %0d last %0b",
                             corner.corner_index, corner.corner_x, corner.corner_y,
                             corner.last_corner));
      end else begin
        want = pending_corners.pop_front();
        if (corner.corner_index !== want.corner_index ||
            corner.corner_x !== want.corner_x ||
            corner.corner_y !== want.corner_y ||
            corner.last_corner !== want.last_corner) begin
          flag_error($sformatf(
            "corner mismatch: expected idx %0d x %0d y %0d last %0b, got idx %0d x %0d y %0d last %0b",
            want.corner_index, want.corner_x, want.corner_y, want.last_corner,
            corner.corner_index, corner.corner_x, corner.corner_y, corner.last_corner));
        end
      end
    end
  end

  // Hang detection: count cycles in which no handshake of any kind happens.
  always @(posedge clk) begin
    if (rst || cfg_write || (pose_valid && !pose_stall) ||
        (corner_valid === 1'b1 && !corner_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    pose_t              p;
    logic [SCALE_W-1:0] w;
    logic [SCALE_W-1:0] h;

    rst            = 1'b1;
    pose_valid     = 1'b0;
    pose           = '0;
    cfg_write      = 1'b0;
    cfg_index      = CFG_WIDTH_SCALE;
    cfg_data       = '0;
    errors         = 0;
    idle_cycles    = 0;
    idle_en        = 1'b1;
    width_scale_q  = DEFAULT_WIDTH_SCALE;
    height_scale_q = DEFAULT_HEIGHT_SCALE;

    for (int k = 0; k <= 90; k++) begin
      sine_q16[k] = quarter_sine(k);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed poses run on the scales left by reset.
    for (int i = 0; i < DIR_ROWS; i++) begin
      p.center_x    = COORD_W'(dir_rows[i].cx);
      p.center_y    = COORD_W'(dir_rows[i].cy);
      p.altitude    = ALT_W'(dir_rows[i].alt);
      p.heading_deg = HEAD_W'(dir_rows[i].hdg);
      send_pose(p, dir_rows[i].pinned, PIX_W'(dir_rows[i].px), PIX_W'(dir_rows[i].py));
    end

    // Random phases, each on its own scale setting. Full scales push most
    // corners into saturation, zero scales collapse the box, the last phase
    // returns to the defaults and runs with no idling at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_corners();
      case (ph)
        0: begin
          w = FULL_SCALE;
          h = FULL_SCALE;
        end
        1: begin
          w = '0;
          h = '0;
        end
        2: begin
          w = '0;
          h = FULL_SCALE;
        end
        3: begin
          w = SCALE_W'($urandom_range(0, 24'hFFFFFF));
          h = SCALE_W'($urandom_range(0, 24'hFFFFFF));
        end
        4: begin
          w = SCALE_W'($urandom_range(0, 24'h0FFFFF));
          h = SCALE_W'($urandom_range(0, 24'h0FFFFF));
        end
        default: begin
          w = DEFAULT_WIDTH_SCALE;
          h = DEFAULT_HEIGHT_SCALE;
        end
      endcase
      idle_en = (ph != PHASES - 1);
      set_scales(w, h);
      for (int i = 0; i < POSES_PER_PHASE; i++) begin
        send_pose(random_pose(), 1'b0, '0, '0);
      end
    end

    drain_corners();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_corners.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rvbc_pkg.sv
rtl/rvbc_front.sv
rtl/rvbc_rotate.sv
rtl/rvbc_corner.sv
rtl/rotated_view_box_corners.sv
tb/testbench.sv
